@@ rtl/cnp_pkg.sv @@
// Shared character codes, character classes and cell status types for the CSV cell parser.
package cnp_pkg;

  // Integer part of the fixed-point result is always 32 bits wide
  localparam int INTEGER_BITS = 32;

  // Character codes
  localparam logic [7:0] CHAR_COMMA   = 8'h2C;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_POINT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_VTAB    = 8'h0B;
  localparam logic [7:0] CHAR_FFEED   = 8'h0C;
  localparam logic [7:0] CHAR_CR      = 8'h0D;

  // Fraction digit index saturates here; every weight past it is zero
  localparam logic [3:0] FRAC_IDX_MAX = 4'd10;

  typedef enum logic [2:0] {
    CC_SEP,
    CC_SPACE,
    CC_DIGIT,
    CC_POINT,
    CC_OTHER
  } char_class_t;

  // Status flags of a finished cell
  typedef struct packed {
    logic is_number;
    logic text_empty;
  } cell_flags_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t cls;
    if (c == CHAR_COMMA || c == CHAR_NEWLINE) begin
      cls = CC_SEP;
    end else if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VTAB ||
                 c == CHAR_FFEED || c == CHAR_CR) begin
      cls = CC_SPACE;
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      cls = CC_DIGIT;
    end else if (c == CHAR_POINT) begin
      cls = CC_POINT;
    end else begin
      cls = CC_OTHER;
    end
    return cls;
  endfunction

endpackage

@@ rtl/cnp_cell_acc.sv @@
// Per-cell accumulator: trim tracking, numeric check and fixed-point value build-up.
module cnp_cell_acc #(
  parameter int POSITION_BITS = 32,
  parameter int FRACTION_BITS = 24
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           step,
  input  logic [7:0]                                     text_byte,
  input  logic [POSITION_BITS-1:0]                       pos,
  output cnp_pkg::cell_flags_t                           flags,
  output logic [cnp_pkg::INTEGER_BITS+FRACTION_BITS-1:0] value,
  output logic [POSITION_BITS-1:0]                       first_pos,
  output logic [POSITION_BITS-1:0]                       last_pos
);

  localparam int IB = cnp_pkg::INTEGER_BITS;

  // Weight of the k-th fraction digit: floor(2^F / 10^k)
  localparam logic [FRACTION_BITS-1:0] W1 = FRACTION_BITS'((64'd1 << FRACTION_BITS) / 64'd10);
  localparam logic [FRACTION_BITS-1:0] W2 = FRACTION_BITS'((64'd1 << FRACTION_BITS) / 64'd100);
  localparam logic [FRACTION_BITS-1:0] W3 =
    FRACTION_BITS'((64'd1 << FRACTION_BITS) / 64'd1000);
  localparam logic [FRACTION_BITS-1:0] W4 =
    FRACTION_BITS'((64'd1 << FRACTION_BITS) / 64'd10000);
  localparam logic [FRACTION_BITS-1:0] W5 =
    FRACTION_BITS'((64'd1 << FRACTION_BITS) / 64'd100000);
  localparam logic [FRACTION_BITS-1:0] W6 =
    FRACTION_BITS'((64'd1 << FRACTION_BITS) / 64'd1000000);
  localparam logic [FRACTION_BITS-1:0] W7 =
    FRACTION_BITS'((64'd1 << FRACTION_BITS) / 64'd10000000);
  localparam logic [FRACTION_BITS-1:0] W8 =
    FRACTION_BITS'((64'd1 << FRACTION_BITS) / 64'd100000000);
  localparam logic [FRACTION_BITS-1:0] W9 =
    FRACTION_BITS'((64'd1 << FRACTION_BITS) / 64'd1000000000);

  logic                     seen_r, seen_nxt;
  logic                     pend_r, pend_nxt;
  logic                     ok_r, ok_nxt;
  logic                     point_r, point_nxt;
  logic [IB-1:0]            int_r, int_nxt;
  logic [FRACTION_BITS-1:0] frac_r, frac_nxt;
  logic [3:0]               fidx_r, fidx_nxt;
  logic [POSITION_BITS-1:0] first_r, first_nxt;
  logic [POSITION_BITS-1:0] last_r, last_nxt;

  cnp_pkg::char_class_t     cls;
  logic [3:0]               digit;
  logic [FRACTION_BITS-1:0] weight;
  logic [IB+3:0]            int_x10;
  logic [FRACTION_BITS+3:0] frac_add;
  logic                     ok_eff;

  assign cls   = cnp_pkg::classify(text_byte);
  assign digit = 4'(text_byte - cnp_pkg::CHAR_ZERO);

  // Fraction digit weight lookup
  always_comb begin
    case (fidx_r)
      4'd1:    weight = W1;
      4'd2:    weight = W2;
      4'd3:    weight = W3;
      4'd4:    weight = W4;
      4'd5:    weight = W5;
      4'd6:    weight = W6;
      4'd7:    weight = W7;
      4'd8:    weight = W8;
      4'd9:    weight = W9;
      default: weight = '0;
    endcase
  end

  // x*10 + d as shift-add, and the fraction multiply-add
  assign int_x10  = {1'b0, int_r, 3'b000} + {3'b000, int_r, 1'b0} + {{IB{1'b0}}, digit};
  assign frac_add = {4'b0000, frac_r} +
                    ({4'b0000, weight} * {{FRACTION_BITS{1'b0}}, digit});

  // Content after trailing whitespace breaks the number
  assign ok_eff = ok_r && !(seen_r && pend_r);

  // Next-state logic for one byte
  always_comb begin
    seen_nxt  = seen_r;
    pend_nxt  = pend_r;
    ok_nxt    = ok_r;
    point_nxt = point_r;
    int_nxt   = int_r;
    frac_nxt  = frac_r;
    fidx_nxt  = fidx_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    case (cls)
      cnp_pkg::CC_SEP: begin
        seen_nxt  = 1'b0;
        pend_nxt  = 1'b0;
        ok_nxt    = 1'b1;
        point_nxt = 1'b0;
        int_nxt   = '0;
        frac_nxt  = '0;
        fidx_nxt  = '0;
        first_nxt = '0;
        last_nxt  = '0;
      end
      cnp_pkg::CC_SPACE: begin
        if (seen_r) begin
          pend_nxt = 1'b1;
        end
      end
      default: begin
        if (!seen_r) begin
          seen_nxt  = 1'b1;
          first_nxt = pos;
        end
        pend_nxt = 1'b0;
        last_nxt = pos;
        ok_nxt   = ok_eff;
        if (ok_eff) begin
          if (cls == cnp_pkg::CC_DIGIT) begin
            if (!point_r) begin
              int_nxt = (int_x10[IB+3:IB] != 4'd0) ? {IB{1'b1}} : int_x10[IB-1:0];
            end else begin
              frac_nxt = frac_add[FRACTION_BITS-1:0];
              if (fidx_r != cnp_pkg::FRAC_IDX_MAX) begin
                fidx_nxt = fidx_r + 4'd1;
              end
            end
          end else if (cls == cnp_pkg::CC_POINT) begin
            if (point_r) begin
              ok_nxt = 1'b0;
            end else begin
              point_nxt = 1'b1;
              fidx_nxt  = 4'd1;
            end
          end else begin
            ok_nxt = 1'b0;
          end
        end
      end
    endcase
  end

  // Cell state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= 1'b0;
      pend_r  <= 1'b0;
      ok_r    <= 1'b1;
      point_r <= 1'b0;
      int_r   <= '0;
      frac_r  <= '0;
      fidx_r  <= '0;
      first_r <= '0;
      last_r  <= '0;
    end else if (step) begin
      seen_r  <= seen_nxt;
      pend_r  <= pend_nxt;
      ok_r    <= ok_nxt;
      point_r <= point_nxt;
      int_r   <= int_nxt;
      frac_r  <= frac_nxt;
      fidx_r  <= fidx_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
    end
  end

  // Cell summary as seen at a separator
  assign flags.is_number  = ok_r;
  assign flags.text_empty = !seen_r;
  assign value            = ok_r ? {int_r, frac_r} : '0;
  assign first_pos        = seen_r ? first_r : '0;
  assign last_pos         = seen_r ? last_r : '0;

endmodule

@@ rtl/csv_cell_number_parser.sv @@
// CSV cell splitter with whitespace trim and decimal-to-Q32.F fixed-point parse.
//
// Accepts one text byte per clock and emits one result transaction for every comma or
// newline, describing the cell it closes. Each byte is captured into an input register
// and processed from there by a single pass of shift-add and small multiply-add logic;
// a cell result is registered in the output register when its separator byte leaves
// the input register. Sustained rate is one byte per cycle; the input only
// stalls when a separator reaches the processing stage while the output register still
// holds an untaken result. Positions count every byte, separators included, and wrap
// at 2^POSITION_BITS.
module csv_cell_number_parser #(
  parameter int POSITION_BITS = 32,
  parameter int FRACTION_BITS = 24
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_valid,
  output logic                                           in_stall,
  input  logic [7:0]                                     in_text_byte,
  output logic                                           out_valid,
  input  logic                                           out_stall,
  output logic                                           out_is_number,
  output logic [cnp_pkg::INTEGER_BITS+FRACTION_BITS-1:0] out_number_value,
  output logic                                           out_text_empty,
  output logic [POSITION_BITS-1:0]                       out_text_first,
  output logic [POSITION_BITS-1:0]                       out_text_last,
  output logic                                           out_row_end
);

  localparam int VB = cnp_pkg::INTEGER_BITS + FRACTION_BITS;

  logic                     in_vld_r;
  logic [7:0]               in_byte_r;
  logic [POSITION_BITS-1:0] pos_r;
  logic                     is_sep;
  logic                     adv;
  logic                     in_acc;

  cnp_pkg::cell_flags_t     flags;
  logic [VB-1:0]            value;
  logic [POSITION_BITS-1:0] first_pos;
  logic [POSITION_BITS-1:0] last_pos;

  logic                     out_vld_r;
  logic                     is_num_r;
  logic [VB-1:0]            value_r;
  logic                     empty_r;
  logic [POSITION_BITS-1:0] first_r;
  logic [POSITION_BITS-1:0] last_r;
  logic                     row_end_r;

  // Handshake: a separator needs a free output slot, other bytes always move on
  assign is_sep   = (cnp_pkg::classify(in_byte_r) == cnp_pkg::CC_SEP);
  assign adv      = in_vld_r && (!is_sep || !out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  // Input register and byte position counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      pos_r    <= '0;
    end else begin
      if (in_acc) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv) begin
        pos_r <= pos_r + POSITION_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_text_byte;
    end
  end

  cnp_cell_acc #(
    .POSITION_BITS (POSITION_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_cell (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .text_byte (in_byte_r),
    .pos       (pos_r),
    .flags     (flags),
    .value     (value),
    .first_pos (first_pos),
    .last_pos  (last_pos)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && is_sep) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && is_sep) begin
      is_num_r  <= flags.is_number;
      value_r   <= value;
      empty_r   <= flags.text_empty;
      first_r   <= first_pos;
      last_r    <= last_pos;
      row_end_r <= (in_byte_r == cnp_pkg::CHAR_NEWLINE);
    end
  end

  assign out_valid        = out_vld_r;
  assign out_is_number    = is_num_r;
  assign out_number_value = value_r;
  assign out_text_empty   = empty_r;
  assign out_text_first   = first_r;
  assign out_text_last    = last_r;
  assign out_row_end      = row_end_r;

endmodule

@@ rtl/cnp_checker.sv @@
// Port-level assertion checker for the CSV cell parser, bound to the top level.
module cnp_checker #(
  parameter int POSITION_BITS = 32,
  parameter int FRACTION_BITS = 24
) (
  input logic                                           clk,
  input logic                                           rst_n,
  input logic                                           in_stall,
  input logic                                           out_valid,
  input logic                                           out_stall,
  input logic                                           out_is_number,
  input logic [cnp_pkg::INTEGER_BITS+FRACTION_BITS-1:0] out_number_value,
  input logic                                           out_text_empty,
  input logic [POSITION_BITS-1:0]                       out_text_first,
  input logic [POSITION_BITS-1:0]                       out_text_last,
  input logic                                           out_row_end
);

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_number_value) &&
      $stable(out_text_first) && $stable(out_row_end))
    else $error("result changed while stalled");

  // Input only backs up behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with result path free");

  // Non-numeric cells carry a zero value
  a_nonnum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_number |-> out_number_value == '0)
    else $error("non-numeric cell with nonzero value");

  // Empty cells report zero positions
  a_empty_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_empty |-> out_text_first == '0 && out_text_last == '0)
    else $error("empty cell with nonzero positions");

  // Empty cells count as the number zero
  a_empty_num: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_empty |-> out_is_number && out_number_value == '0)
    else $error("empty cell not reported as zero");

endmodule

bind csv_cell_number_parser cnp_checker #(
  .POSITION_BITS (POSITION_BITS),
  .FRACTION_BITS (FRACTION_BITS)
) u_cnp_checker (.*);

@@ sim/cell_check_pkg.sv @@
// Expected-cell predictor and result checker for the CSV cell parser testbench.
package cell_check_pkg;

  localparam int FRAC_W  = 24;
  localparam int POS_W   = 32;
  localparam int VALUE_W = cnp_pkg::INTEGER_BITS + FRAC_W;

  // One finished cell as seen on the result channel
  typedef struct packed {
    logic               is_number;
    logic [VALUE_W-1:0] number_value;
    logic               text_empty;
    logic [POS_W-1:0]   text_first;
    logic [POS_W-1:0]   text_last;
    logic               row_end;
  } cell_result_t;

  class cell_scoreboard;
    cell_result_t                     expected_cells[$];
    int unsigned                      mismatch_count;
    // running state of the cell being parsed
    logic [POS_W-1:0]                 next_pos;
    logic                             has_text;
    logic                             trail_space;
    logic                             numeric;
    logic                             got_point;
    logic [cnp_pkg::INTEGER_BITS-1:0] int_part;
    logic [FRAC_W-1:0]                frac_part;
    logic [FRAC_W-1:0]                frac_weight;
    logic [POS_W-1:0]                 first_pos;
    logic [POS_W-1:0]                 last_pos;

    function new();
      next_pos       = '0;
      mismatch_count = 0;
      clear_cell();
    endfunction

    function void clear_cell();
      has_text    = 1'b0;
      trail_space = 1'b0;
      numeric     = 1'b1;
      got_point   = 1'b0;
      int_part    = '0;
      frac_part   = '0;
      frac_weight = '0;
      first_pos   = '0;
      last_pos    = '0;
    endfunction

    function int pending();
      return expected_cells.size();
    endfunction

    // Advance the parse by one accepted byte; a separator queues the finished cell
    function void note_byte(logic [7:0] c);
      logic [POS_W-1:0] pos;
      logic [63:0]      wide;
      cell_result_t     fin_cell;
      pos      = next_pos;
      next_pos = next_pos + POS_W'(1);

      if (c == cnp_pkg::CHAR_COMMA || c == cnp_pkg::CHAR_NEWLINE) begin
        fin_cell.is_number    = numeric;
        fin_cell.number_value = numeric ? {int_part, frac_part} : '0;
        fin_cell.text_empty   = !has_text;
        fin_cell.text_first   = has_text ? first_pos : '0;
        fin_cell.text_last    = has_text ? last_pos : '0;
        fin_cell.row_end      = (c == cnp_pkg::CHAR_NEWLINE);
        expected_cells.push_back(fin_cell);
        clear_cell();
        return;
      end

      // whitespace only matters once text has started (possible interior gap)
      if (c inside {cnp_pkg::CHAR_SPACE, cnp_pkg::CHAR_TAB, cnp_pkg::CHAR_VTAB,
                    cnp_pkg::CHAR_FFEED, cnp_pkg::CHAR_CR}) begin
        if (has_text) trail_space = 1'b1;
        return;
      end

      if (!has_text) begin
        has_text  = 1'b1;
        first_pos = pos;
      end else if (trail_space) begin
        numeric = 1'b0;
      end
      trail_space = 1'b0;
      last_pos    = pos;
      if (!numeric) return;

      if (c >= cnp_pkg::CHAR_ZERO && c <= cnp_pkg::CHAR_NINE) begin
        if (!got_point) begin
          // integer part saturates at all ones
          wide     = 64'(int_part) * 64'd10 + 64'(c - cnp_pkg::CHAR_ZERO);
          int_part = (wide > 64'({cnp_pkg::INTEGER_BITS{1'b1}})) ? '1 :
                     wide[cnp_pkg::INTEGER_BITS-1:0];
        end else begin
          wide        = 64'(frac_part) + 64'(frac_weight) * 64'(c - cnp_pkg::CHAR_ZERO);
          frac_part   = wide[FRAC_W-1:0];
          frac_weight = frac_weight / FRAC_W'(10);
        end
      end else if (c == cnp_pkg::CHAR_POINT) begin
        if (got_point) begin
          numeric = 1'b0;
        end else begin
          got_point   = 1'b1;
          frac_weight = FRAC_W'((64'd1 << FRAC_W) / 64'd10);
        end
      end else begin
        numeric = 1'b0;
      end
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] seen);
      if (seen !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, seen);
        mismatch_count++;
      end
    endfunction

    // Compare one accepted result transaction with the oldest expected cell
    function void check_cell(cell_result_t got);
      cell_result_t want;
      if (expected_cells.size() == 0) begin
        $error("cell result with none expected");
        mismatch_count++;
        return;
      end
      want = expected_cells.pop_front();
      compare_field("is_number", 64'(want.is_number), 64'(got.is_number));
      compare_field("number_value", 64'(want.number_value), 64'(got.number_value));
      compare_field("text_empty", 64'(want.text_empty), 64'(got.text_empty));
      compare_field("text_first", 64'(want.text_first), 64'(got.text_first));
      compare_field("text_last", 64'(want.text_last), 64'(got.text_last));
      compare_field("row_end", 64'(want.row_end), 64'(got.row_end));
    endfunction
  endclass

endpackage

@@ sim/tb.sv @@
// Top-level testbench for csv_cell_number_parser: byte stream driver, stall control, checks.
module tb;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 240;
  localparam int PHASE_BYTES  = 360;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic [7:0]                        in_text_byte;
  logic                              out_valid;
  logic                              out_stall;
  logic                              out_is_number;
  logic [cell_check_pkg::VALUE_W-1:0] out_number_value;
  logic                              out_text_empty;
  logic [cell_check_pkg::POS_W-1:0]  out_text_first;
  logic [cell_check_pkg::POS_W-1:0]  out_text_last;
  logic                              out_row_end;

  cell_check_pkg::cell_scoreboard sb;
  logic [7:0]     text_stream[$];
  int             send_idle_pct;
  int             recv_stall_pct;
  int             hold_reqs = 0;
  int             hold_seen = 0;
  int             hold_left = 0;
  int unsigned    cycle_count = 0;

  csv_cell_number_parser u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_is_number    (out_is_number),
    .out_number_value (out_number_value),
    .out_text_empty   (out_text_empty),
    .out_text_first   (out_text_first),
    .out_text_last    (out_text_last),
    .out_row_end      (out_row_end)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("csv_cell_number_parser test failed");
      $finish;
    end
  end

  // Receiver stall: long hold-off on request, otherwise random
  always @(negedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_left = HOLD_CYCLES;
      hold_seen = hold_reqs;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor both channels at the rising edge
  always @(posedge clk) begin
    cell_check_pkg::cell_result_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_byte(in_text_byte);
      if (out_valid && !out_stall) begin
        got.is_number    = out_is_number;
        got.number_value = out_number_value;
        got.text_empty   = out_text_empty;
        got.text_first   = out_text_first;
        got.text_last    = out_text_last;
        got.row_end      = out_row_end;
        sb.check_cell(got);
      end
    end
  end

  function automatic logic [7:0] pick_space();
    case ($urandom_range(4))
      0: return cnp_pkg::CHAR_SPACE;
      1: return cnp_pkg::CHAR_TAB;
      2: return cnp_pkg::CHAR_VTAB;
      3: return cnp_pkg::CHAR_FFEED;
      default: return cnp_pkg::CHAR_CR;
    endcase
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) text_stream.push_back(s[i]);
  endtask

  task automatic push_digits(input int n);
    repeat (n) text_stream.push_back(cnp_pkg::CHAR_ZERO + 8'($urandom_range(9)));
  endtask

  // One random cell plus separator; mostly well-formed numbers
  task automatic add_random_cell();
    int kind;
    int start;
    int spot;
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(3)) text_stream.push_back(pick_space());
    end else if (kind < 80) begin
      start = text_stream.size();
      repeat ($urandom_range(2)) text_stream.push_back(pick_space());
      // long integer parts exercise saturation
      push_digits(($urandom_range(7) == 0) ? $urandom_range(14, 10) : $urandom_range(6));
      if ($urandom_range(1)) begin
        text_stream.push_back(cnp_pkg::CHAR_POINT);
        // long fractions run the digit weight down to zero
        push_digits(($urandom_range(3) == 0) ? $urandom_range(12, 7) : $urandom_range(4));
      end
      repeat ($urandom_range(2)) text_stream.push_back(pick_space());
      // corrupt one byte now and then
      if ($urandom_range(5) == 0 && text_stream.size() > start) begin
        spot = $urandom_range(text_stream.size() - 1, start);
        case ($urandom_range(2))
          0: text_stream[spot] = 8'($urandom_range(255));
          1: text_stream[spot] = cnp_pkg::CHAR_POINT;
          default: text_stream[spot] = pick_space();
        endcase
      end
    end else begin
      repeat ($urandom_range(6, 1)) text_stream.push_back(8'($urandom_range(255)));
    end
    text_stream.push_back(($urandom_range(9) < 3) ? cnp_pkg::CHAR_NEWLINE :
                                                     cnp_pkg::CHAR_COMMA);
  endtask

  // Offer one byte from a falling edge and hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_stream(input int hold_at);
    for (int i = 0; i < text_stream.size(); i++) begin
      if (i == hold_at) hold_reqs++;
      send_byte(text_stream[i]);
    end
    in_valid <= 1'b0;
    text_stream.delete();
  endtask

  task automatic wait_cells_done();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    in_valid       = 1'b0;
    in_text_byte   = '0;
    rst_n          = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    sb             = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: saturation, NUL, lone point, second point, interior gap,
    // high byte, empty and whitespace-only cells
    push_text("4294967296");
    text_stream.push_back(cnp_pkg::CHAR_COMMA);
    text_stream.push_back(8'h00);
    text_stream.push_back(cnp_pkg::CHAR_COMMA);
    push_text(" .");
    text_stream.push_back(cnp_pkg::CHAR_TAB);
    text_stream.push_back(cnp_pkg::CHAR_COMMA);
    push_text("1.2.3");
    text_stream.push_back(cnp_pkg::CHAR_NEWLINE);
    push_text("7 8");
    text_stream.push_back(cnp_pkg::CHAR_COMMA);
    text_stream.push_back(8'hFF);
    text_stream.push_back(cnp_pkg::CHAR_COMMA);
    text_stream.push_back(cnp_pkg::CHAR_NEWLINE);
    text_stream.push_back(cnp_pkg::CHAR_VTAB);
    text_stream.push_back(cnp_pkg::CHAR_FFEED);
    text_stream.push_back(cnp_pkg::CHAR_CR);
    text_stream.push_back(cnp_pkg::CHAR_COMMA);
    send_stream(-1);
    wait_cells_done();

    // Random phases: sender-light/receiver-heavy, the reverse, then free running
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct  = 25;
          recv_stall_pct = 76;
        end
        1: begin
          send_idle_pct  = 76;
          recv_stall_pct = 25;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      while (text_stream.size() < PHASE_BYTES) add_random_cell();
      // last phase: long receiver hold-off while bytes keep coming
      send_stream((p == 2) ? 80 : -1);
      wait_cells_done();
    end

    repeat (8) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("csv_cell_number_parser test passed");
    end else begin
      $display("csv_cell_number_parser test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/cnp_pkg.sv
rtl/cnp_cell_acc.sv
rtl/csv_cell_number_parser.sv
rtl/cnp_checker.sv
sim/cell_check_pkg.sv
sim/tb.sv
